// File: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// types and constants shared by the buddy page allocator modules
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_ORDER  = 11;
  localparam int PAGE_COUNT = 4096;
  localparam int PAGE_W     = 12;
  localparam int ORD_W      = 4;
  localparam int LINK_W     = 13;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGE_COUNT);

  localparam logic       CMD_ALLOC = 1'b0;
  localparam logic       CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [ORD_W-1:0]  req_order;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] block_index;
    logic [ORD_W-1:0]  block_order;
  } rsp_t;

  // per-page metadata word
  typedef struct packed {
    logic [ORD_W-1:0]  order;
    logic              free;
    logic              head;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } meta_t;

  localparam int META_W = $bits(meta_t);

endpackage

// File: sv/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// sequencer for search, split, merge and free-list link updates
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bpa_pkg::req_t cmd_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpa_pkg::rsp_t rsp_data
);
  import bpa_pkg::*;

  typedef enum logic [22:0] {
    S_CLEAR  = 23'd1 << 0,
    S_IDLE   = 23'd1 << 1,
    S_SRCH   = 23'd1 << 2,
    S_SPLIT  = 23'd1 << 3,
    S_FIN_RD = 23'd1 << 4,
    S_FIN_WR = 23'd1 << 5,
    S_F_RD   = 23'd1 << 6,
    S_F_CHK  = 23'd1 << 7,
    S_M_CHK  = 23'd1 << 8,
    S_M_TST  = 23'd1 << 9,
    S_M_NEXT = 23'd1 << 10,
    S_U_RD   = 23'd1 << 11,
    S_U_WR   = 23'd1 << 12,
    S_U_PV   = 23'd1 << 13,
    S_U_PVW  = 23'd1 << 14,
    S_U_NX   = 23'd1 << 15,
    S_U_NXW  = 23'd1 << 16,
    S_P_RD   = 23'd1 << 17,
    S_P_WR   = 23'd1 << 18,
    S_P_H    = 23'd1 << 19,
    S_P_HW   = 23'd1 << 20,
    S_RESP   = 23'd1 << 21,
    S_U_CLR  = 23'd1 << 22
  } state_t;

  state_t            state;
  logic [PAGE_W-1:0] clr_cnt;
  logic [LINK_W-1:0] free_head [MAX_ORDER];
  logic              op_free;
  logic [ORD_W-1:0]  req;
  logic [ORD_W-1:0]  cur;
  logic [ORD_W-1:0]  ord;
  logic [PAGE_W-1:0] p;
  logic [PAGE_W-1:0] b;
  logic [PAGE_W-1:0] ua;
  logic [ORD_W-1:0]  uord;
  logic              uhead;
  logic [LINK_W-1:0] pv;
  logic [LINK_W-1:0] nx;
  logic [PAGE_W-1:0] pa;
  logic [ORD_W-1:0]  pord;
  logic [LINK_W-1:0] ph;
  rsp_t              res;

  logic              we;
  logic [PAGE_W-1:0] waddr;
  meta_t             wdata;
  logic [PAGE_W-1:0] raddr;
  meta_t             rdata;
  logic [META_W-1:0] rdata_raw;
  logic [PAGE_W-1:0] b_next;
  logic [ORD_W-1:0]  cur_m1;

  assign rdata     = meta_t'(rdata_raw);
  assign b_next    = p ^ (PAGE_W'(1) << ord);
  assign cur_m1    = cur - ORD_W'(1);
  assign cmd_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign rsp_data  = res;

  bpa_ram #(
    .WIDTH(META_W),
    .DEPTH(PAGE_COUNT)
  ) u_meta (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '{order: '0, free: 1'b0, head: 1'b0, next: NIL, prev: NIL};
      end
      S_U_RD:   raddr = ua;
      S_U_PV:   raddr = pv[PAGE_W-1:0];
      S_U_PVW: begin
        we         = 1'b1;
        waddr      = pv[PAGE_W-1:0];
        wdata.next = nx;
      end
      S_U_NX:   raddr = nx[PAGE_W-1:0];
      S_U_NXW: begin
        we         = 1'b1;
        waddr      = nx[PAGE_W-1:0];
        wdata.prev = pv;
      end
      // neighbours are patched first, then the unlinked page is cleared
      S_U_CLR: begin
        we    = 1'b1;
        waddr = ua;
        wdata = '{order: '0, free: 1'b0, head: uhead, next: NIL, prev: NIL};
      end
      S_P_RD:   raddr = pa;
      S_P_WR: begin
        we          = 1'b1;
        waddr       = pa;
        wdata.next  = free_head[pord];
        wdata.prev  = NIL;
        wdata.order = pord;
        wdata.free  = 1'b1;
      end
      S_P_H:    raddr = ph[PAGE_W-1:0];
      S_P_HW: begin
        we         = 1'b1;
        waddr      = ph[PAGE_W-1:0];
        wdata.prev = {1'b0, pa};
      end
      S_FIN_RD: raddr = p;
      S_FIN_WR: begin
        we          = 1'b1;
        waddr       = p;
        wdata.order = req;
        wdata.head  = 1'b1;
      end
      S_F_RD:   raddr = p;
      S_F_CHK: begin
        we         = !rdata.free;
        waddr      = p;
        wdata.head = 1'b0;
      end
      S_M_CHK:  raddr = b_next;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        free_head[i] <= NIL;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + PAGE_W'(1);
          if (clr_cnt == PAGE_W'(PAGE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            op_free <= (cmd_data.cmd == CMD_FREE);
            req     <= cmd_data.req_order;
            cur     <= cmd_data.req_order;
            p       <= cmd_data.page_index;
            if (cmd_data.cmd == CMD_FREE) begin
              if ({1'b0, cmd_data.page_index} >= NIL) begin
                res   <= '{status: ST_RANGE, block_index: '0, block_order: '0};
                state <= S_RESP;
              end else begin
                state <= S_F_RD;
              end
            end else if (cmd_data.req_order >= ORD_W'(MAX_ORDER)) begin
              res   <= '{status: ST_RANGE, block_index: '0, block_order: '0};
              state <= S_RESP;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (!free_head[cur][LINK_W-1]) begin
            p     <= free_head[cur][PAGE_W-1:0];
            ua    <= free_head[cur][PAGE_W-1:0];
            uord  <= cur;
            state <= S_U_RD;
          end else if (cur == ORD_W'(MAX_ORDER - 1)) begin
            res   <= '{status: ST_NOSPACE, block_index: '0, block_order: '0};
            state <= S_RESP;
          end else begin
            cur <= cur + ORD_W'(1);
          end
        end
        // unlink ua from list uord
        S_U_RD: state <= S_U_WR;
        S_U_WR: begin
          pv    <= rdata.prev;
          nx    <= rdata.next;
          uhead <= rdata.head;
          state <= S_U_PV;
        end
        S_U_PV: begin
          if (!pv[LINK_W-1]) begin
            state <= S_U_PVW;
          end else begin
            free_head[uord] <= nx;
            state           <= S_U_NX;
          end
        end
        S_U_PVW: state <= S_U_NX;
        S_U_NX: begin
          if (!nx[LINK_W-1]) begin
            state <= S_U_NXW;
          end else begin
            state <= S_U_CLR;
          end
        end
        S_U_NXW: state <= S_U_CLR;
        S_U_CLR: state <= op_free ? S_M_NEXT : S_SPLIT;
        S_SPLIT: begin
          if (cur > req) begin
            cur   <= cur_m1;
            pa    <= p | (PAGE_W'(1) << cur_m1);
            pord  <= cur_m1;
            state <= S_P_RD;
          end else begin
            state <= S_FIN_RD;
          end
        end
        // push pa onto list pord
        S_P_RD: state <= S_P_WR;
        S_P_WR: begin
          ph              <= free_head[pord];
          free_head[pord] <= {1'b0, pa};
          if (!free_head[pord][LINK_W-1]) begin
            state <= S_P_H;
          end else begin
            state <= op_free ? S_RESP : S_SPLIT;
          end
        end
        S_P_H:  state <= S_P_HW;
        S_P_HW: state <= op_free ? S_RESP : S_SPLIT;
        S_FIN_RD: state <= S_FIN_WR;
        S_FIN_WR: begin
          res   <= '{status: ST_DONE, block_index: p, block_order: req};
          state <= S_RESP;
        end
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          if (rdata.free) begin
            res   <= '{status: ST_DONE, block_index: p, block_order: rdata.order};
            state <= S_RESP;
          end else begin
            ord   <= (rdata.order >= ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER - 1)
                                                        : rdata.order;
            state <= S_M_CHK;
          end
        end
        S_M_CHK: begin
          b <= b_next;
          if (ord < ORD_W'(MAX_ORDER - 1) && {1'b0, b_next} < NIL) begin
            state <= S_M_TST;
          end else begin
            pa    <= p;
            pord  <= ord;
            res   <= '{status: ST_DONE, block_index: p, block_order: ord};
            state <= S_P_RD;
          end
        end
        S_M_TST: begin
          if (rdata.free && rdata.order == ord) begin
            ua    <= b;
            uord  <= ord;
            state <= S_U_RD;
          end else begin
            pa    <= p;
            pord  <= ord;
            res   <= '{status: ST_DONE, block_index: p, block_order: ord};
            state <= S_P_RD;
          end
        end
        S_M_NEXT: begin
          p     <= p & ~(PAGE_W'(1) << ord);
          ord   <= ord + ORD_W'(1);
          state <= S_M_CHK;
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/buddy_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// buddy allocator over 4096 pages, orders 0 to 10, one free list per order
// ----------------------------------------------------------------------------
// a command transfer on cmd_* either allocates a block of req_order or frees
// the block that starts at page_index; each command gives one result
// transfer on res_* with status, block index and block order.
// the block takes one command at a time: cmd_ready is high only while the
// sequencer is idle. an allocate searches the lists from req_order up,
// unlinks the block found and splits it down to req_order, pushing each
// upper half; a free changes nothing when the page is already free,
// otherwise it merges with each free buddy of equal order, unlinking it,
// and pushes the merged block. the steps are set by the one-write,
// one-read metadata ram: every link update is a read followed by a
// write of the page word.
// after reset a clearing pass writes every page word; no command is taken
// until it ends. the pool starts empty and is filled by freeing every
// page once.
// the result sits in an output register; a stalled receiver holds it there
// while the next command is already taken and worked on.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bpa_pkg::req_t cmd_data,
  output logic          res_valid,
  input  logic          res_ready,
  output bpa_pkg::rsp_t res_data
);
  import bpa_pkg::*;

  logic ctl_valid;
  logic ctl_ready;
  rsp_t ctl_data;

  assign ctl_ready = !res_valid || res_ready;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data),
    .rsp_valid(ctl_valid),
    .rsp_ready(ctl_ready),
    .rsp_data (ctl_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl_ready) begin
      res_valid <= ctl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_ready && ctl_valid) begin
      res_data <= ctl_data;
    end
  end

endmodule
